### rtl/core/tdf_pkg.sv
`timescale 1ns / 1ps

package tdf_pkg;

	// default operand width and fixed field widths
	localparam int VALUE_BITS_DEF = 32;
	localparam int LIMIT_BITS     = 6;
	localparam int INDEX_BITS     = 5;
	localparam int PC_BITS        = 5;

	localparam logic [LIMIT_BITS-1:0] LIMIT_MIN   = 6'd1;
	localparam logic [LIMIT_BITS-1:0] LIMIT_MAX   = 6'd32;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd32;

	// jump conditions tested by the sequencer
	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_IN_VALID,
		COND_LIM1,
		COND_EVEN4,
		COND_OUT_FULL,
		COND_KLAST,
		COND_DIV_BUSY,
		COND_Q_LT_D,
		COND_REM_NZ
	} cond_t;

	// remainder register operations
	typedef enum logic [1:0] {
		X_HOLD,
		X_SHR,
		X_QUOT
	} x_op_t;

	// trial divisor register operations
	typedef enum logic [1:0] {
		D_HOLD,
		D_INIT,
		D_ADD2
	} d_op_t;

	// factor source for an emitted result
	typedef enum logic [1:0] {
		F_TWO,
		F_D,
		F_X
	} fsel_t;

	// one control word of the microprogram
	typedef struct packed {
		logic               take_in;
		x_op_t              x_op;
		d_op_t              d_op;
		logic               div_start;
		logic               emit;
		fsel_t              fsel;
		logic               last;
		cond_t              cond;
		logic               neg;
		logic [PC_BITS-1:0] target;
	} ctrl_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic lim1;
		logic even4;
		logic out_full;
		logic klast;
		logic div_busy;
		logic q_lt_d;
		logic rem_nz;
	} status_t;

	localparam ctrl_t CTRL_NOP = '{
		take_in:   1'b0,
		x_op:      X_HOLD,
		d_op:      D_HOLD,
		div_start: 1'b0,
		emit:      1'b0,
		fsel:      F_X,
		last:      1'b0,
		cond:      COND_NEVER,
		neg:       1'b0,
		target:    '0
	};

	// microprogram step addresses
	localparam logic [PC_BITS-1:0] P_IDLE      = 5'd0;
	localparam logic [PC_BITS-1:0] P_LIM       = 5'd1;
	localparam logic [PC_BITS-1:0] P_TWO       = 5'd2;
	localparam logic [PC_BITS-1:0] P_TWO_WAIT  = 5'd3;
	localparam logic [PC_BITS-1:0] P_TWO_EMIT  = 5'd4;
	localparam logic [PC_BITS-1:0] P_TWO_CHK   = 5'd5;
	localparam logic [PC_BITS-1:0] P_TWO_END   = 5'd6;
	localparam logic [PC_BITS-1:0] P_ODD       = 5'd7;
	localparam logic [PC_BITS-1:0] P_DIV_GO    = 5'd8;
	localparam logic [PC_BITS-1:0] P_DIV_WAIT  = 5'd9;
	localparam logic [PC_BITS-1:0] P_Q_CHK     = 5'd10;
	localparam logic [PC_BITS-1:0] P_R_CHK     = 5'd11;
	localparam logic [PC_BITS-1:0] P_D_WAIT    = 5'd12;
	localparam logic [PC_BITS-1:0] P_D_EMIT    = 5'd13;
	localparam logic [PC_BITS-1:0] P_D_CHK     = 5'd14;
	localparam logic [PC_BITS-1:0] P_D_END     = 5'd15;
	localparam logic [PC_BITS-1:0] P_ADV       = 5'd16;
	localparam logic [PC_BITS-1:0] P_LAST      = 5'd17;
	localparam logic [PC_BITS-1:0] P_LAST_EMIT = 5'd18;

	// microprogram rom: actions of a step, then jump to target when cond ^ neg
	function automatic ctrl_t rom_word(logic [PC_BITS-1:0] pc);
		ctrl_t cw;
		cw = CTRL_NOP;
		case (pc)
			P_IDLE: begin
				cw.take_in = 1'b1;
				cw.cond    = COND_IN_VALID;
				cw.neg     = 1'b1;
				cw.target  = P_IDLE;
			end
			P_LIM: begin
				cw.cond   = COND_LIM1;
				cw.target = P_LAST;
			end
			P_TWO: begin
				cw.cond   = COND_EVEN4;
				cw.neg    = 1'b1;
				cw.target = P_ODD;
			end
			P_TWO_WAIT: begin
				cw.cond   = COND_OUT_FULL;
				cw.target = P_TWO_WAIT;
			end
			P_TWO_EMIT: begin
				cw.emit = 1'b1;
				cw.fsel = F_TWO;
				cw.x_op = X_SHR;
			end
			P_TWO_CHK: begin
				cw.cond   = COND_KLAST;
				cw.neg    = 1'b1;
				cw.target = P_TWO;
			end
			P_TWO_END: begin
				cw.cond   = COND_ALWAYS;
				cw.target = P_LAST;
			end
			P_ODD: begin
				cw.d_op = D_INIT;
			end
			P_DIV_GO: begin
				cw.div_start = 1'b1;
			end
			P_DIV_WAIT: begin
				cw.cond   = COND_DIV_BUSY;
				cw.target = P_DIV_WAIT;
			end
			P_Q_CHK: begin
				cw.cond   = COND_Q_LT_D;
				cw.target = P_LAST;
			end
			P_R_CHK: begin
				cw.cond   = COND_REM_NZ;
				cw.target = P_ADV;
			end
			P_D_WAIT: begin
				cw.cond   = COND_OUT_FULL;
				cw.target = P_D_WAIT;
			end
			P_D_EMIT: begin
				cw.emit = 1'b1;
				cw.fsel = F_D;
				cw.x_op = X_QUOT;
			end
			P_D_CHK: begin
				cw.cond   = COND_KLAST;
				cw.neg    = 1'b1;
				cw.target = P_DIV_GO;
			end
			P_D_END: begin
				cw.cond   = COND_ALWAYS;
				cw.target = P_LAST;
			end
			P_ADV: begin
				cw.d_op   = D_ADD2;
				cw.cond   = COND_ALWAYS;
				cw.target = P_DIV_GO;
			end
			P_LAST: begin
				cw.cond   = COND_OUT_FULL;
				cw.target = P_LAST;
			end
			P_LAST_EMIT: begin
				cw.emit   = 1'b1;
				cw.fsel   = F_X;
				cw.last   = 1'b1;
				cw.cond   = COND_ALWAYS;
				cw.target = P_IDLE;
			end
			default: begin
				cw.cond   = COND_ALWAYS;
				cw.target = P_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

### rtl/core/tdf_div.sv
`timescale 1ns / 1ps

module tdf_div #(
	parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  busy,
	output logic [VALUE_BITS-1:0] quot,
	output logic [VALUE_BITS-1:0] rem
);

	localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [VALUE_BITS:0]   shift;
	logic [VALUE_BITS:0]   diff;
	logic                  ge;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		shift = {rem_q, quo_q[VALUE_BITS-1]};
		ge    = shift >= {1'b0, div_q};
		diff  = shift - {1'b0, div_q};
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(VALUE_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	// quotient and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[VALUE_BITS-1:0] : shift[VALUE_BITS-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quo_q;
	assign rem  = rem_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("divider started while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy)
		else $error("divider did not run after start");
`endif

endmodule

### rtl/core/tdf_seq.sv
`timescale 1ns / 1ps

module tdf_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  tdf_pkg::status_t status,
	output tdf_pkg::ctrl_t   ctrl
);

	logic [tdf_pkg::PC_BITS-1:0] pc_q;
	logic [tdf_pkg::PC_BITS-1:0] pc_next;
	logic                        cond_val;

	// control word of the current step
	assign ctrl = tdf_pkg::rom_word(pc_q);

	// condition select
	always_comb begin
		case (ctrl.cond)
			tdf_pkg::COND_NEVER:    cond_val = 1'b0;
			tdf_pkg::COND_ALWAYS:   cond_val = 1'b1;
			tdf_pkg::COND_IN_VALID: cond_val = status.in_valid;
			tdf_pkg::COND_LIM1:     cond_val = status.lim1;
			tdf_pkg::COND_EVEN4:    cond_val = status.even4;
			tdf_pkg::COND_OUT_FULL: cond_val = status.out_full;
			tdf_pkg::COND_KLAST:    cond_val = status.klast;
			tdf_pkg::COND_DIV_BUSY: cond_val = status.div_busy;
			tdf_pkg::COND_Q_LT_D:   cond_val = status.q_lt_d;
			tdf_pkg::COND_REM_NZ:   cond_val = status.rem_nz;
			default:                cond_val = 1'b0;
		endcase
	end

	// jump or fall through
	always_comb begin
		if (cond_val ^ ctrl.neg) begin
			pc_next = ctrl.target;
		end else begin
			pc_next = pc_q + tdf_pkg::PC_BITS'(1);
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tdf_pkg::P_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

`ifndef ASSERT_OFF
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take_in |-> pc_q == tdf_pkg::P_IDLE)
		else $error("input taken outside idle step");
`endif

endmodule

### rtl/core/trial_division_factorizer.sv
`timescale 1ns / 1ps

// trial division factorizer
// input channel: in_valid / in_stall with value; a request is taken when
// in_valid is high and in_stall low. in_stall stays high while a value is
// being worked on, so one value is handled at a time.
// output channel: out_valid / out_stall with factor, factor_index, is_last;
// one request per factor in ascending order, is_last on the final one.
// configuration: cfg_valid / cfg_ready with max_factors (always ready);
// write only while idle. zero reads as 1, above 32 reads as 32.
// operation: a microcoded sequencer runs a bit-serial restoring divider.
// a factor of two takes a parity test, a wait for a free output, the emit
// and a limit check; an odd trial divisor that fails takes the start, wait
// steps while the divider is busy, two checks and an advance; one that
// divides also waits for a free output, emits and checks the limit; the
// last result waits for a free output and is then emitted. the worst case,
// a prime near 2**VALUE_BITS, tries about 2**(VALUE_BITS/2 - 1) divisors.
// a value of 0 or 1 needs one division; with a limit of 1 none is run.
// a stalled result is held in the output register; the sequencer waits
// before its next result and meanwhile keeps dividing.
// reset returns to idle, drops any pending result and sets max_factors to 32.
module trial_division_factorizer #(
	parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [VALUE_BITS-1:0]           value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [VALUE_BITS-1:0]           factor,
	output logic [tdf_pkg::INDEX_BITS-1:0]  factor_index,
	output logic                            is_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tdf_pkg::LIMIT_BITS-1:0]  max_factors
);

	tdf_pkg::ctrl_t   ctrl;
	tdf_pkg::status_t status;

	logic [VALUE_BITS-1:0]          x_q;
	logic [VALUE_BITS-1:0]          d_q;
	logic [tdf_pkg::INDEX_BITS-1:0] k_q;
	logic [tdf_pkg::LIMIT_BITS-1:0] lim_q;
	logic [tdf_pkg::LIMIT_BITS-1:0] lim_new;
	logic                           out_valid_q;
	logic [VALUE_BITS-1:0]          factor_q;
	logic [tdf_pkg::INDEX_BITS-1:0] index_q;
	logic                           last_q;
	logic [VALUE_BITS-1:0]          factor_sel;
	logic                           div_busy;
	logic [VALUE_BITS-1:0]          quot;
	logic [VALUE_BITS-1:0]          rem;
	logic                           in_take;

	tdf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	tdf_div #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (x_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.quot     (quot),
		.rem      (rem)
	);

	assign in_stall  = !ctrl.take_in;
	assign in_take   = in_valid && ctrl.take_in;
	assign cfg_ready = 1'b1;

	// saturate the limit on write
	always_comb begin
		if (max_factors < tdf_pkg::LIMIT_MIN) begin
			lim_new = tdf_pkg::LIMIT_MIN;
		end else if (max_factors > tdf_pkg::LIMIT_MAX) begin
			lim_new = tdf_pkg::LIMIT_MAX;
		end else begin
			lim_new = max_factors;
		end
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= tdf_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			lim_q <= lim_new;
		end
	end

	// flags for the sequencer
	always_comb begin
		status.in_valid = in_valid;
		status.lim1     = lim_q == tdf_pkg::LIMIT_MIN;
		status.even4    = (|x_q[VALUE_BITS-1:2]) && !x_q[0];
		status.out_full = out_valid_q;
		status.klast    = {1'b0, k_q} == (lim_q - tdf_pkg::LIMIT_MIN);
		status.div_busy = div_busy;
		status.q_lt_d   = quot < d_q;
		status.rem_nz   = |rem;
	end

	// remainder, trial divisor and factor count
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= value;
		end else begin
			case (ctrl.x_op)
				tdf_pkg::X_SHR:  x_q <= {1'b0, x_q[VALUE_BITS-1:1]};
				tdf_pkg::X_QUOT: x_q <= quot;
				default:         x_q <= x_q;
			endcase
		end
		case (ctrl.d_op)
			tdf_pkg::D_INIT: d_q <= VALUE_BITS'(3);
			tdf_pkg::D_ADD2: d_q <= d_q + VALUE_BITS'(2);
			default:         d_q <= d_q;
		endcase
		if (in_take) begin
			k_q <= '0;
		end else if (ctrl.emit) begin
			k_q <= k_q + tdf_pkg::INDEX_BITS'(1);
		end
	end

	// factor source
	always_comb begin
		case (ctrl.fsel)
			tdf_pkg::F_TWO: factor_sel = VALUE_BITS'(2);
			tdf_pkg::F_D:   factor_sel = d_q;
			tdf_pkg::F_X:   factor_sel = x_q;
			default:        factor_sel = x_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			factor_q <= factor_sel;
			index_q  <= k_q;
			last_q   <= ctrl.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign factor       = factor_q;
	assign factor_index = index_q;
	assign is_last      = last_q;

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> !out_valid_q)
		else $error("result written over a pending one");

	a_take_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second value taken while busy");

	a_index_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, factor_index} < lim_q))
		else $error("factor index beyond limit");
`endif

endmodule
